[design/linear_model_sgd_engine_defines.svh]
// assertion macros for the linear model sgd engine
`ifndef LINEAR_MODEL_SGD_ENGINE_DEFINES_SVH
`define LINEAR_MODEL_SGD_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSGD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LSGD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lsgd_pkg.sv]
// shared widths, codes, control structs and saturation for the sgd engine
package lsgd_pkg;

    localparam int FEAT_W     = 16;
    localparam int WGT_W      = 32;
    localparam int ACC_W      = 56;
    localparam int RATE_W     = 16;
    localparam int FCNT_W     = 7;
    localparam int RG_W       = 33;
    localparam int PROD_W     = 49;
    localparam int SAT_W      = 58;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int FWD_SHIFT  = 12;
    localparam int BWD_SHIFT  = 16;
    localparam int BIAS_SHIFT = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 8'd1;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd656;
    localparam logic [FCNT_W-1:0] FCNT_RESET = 7'd64;

    // weight memory port control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } wmem_ctrl_t;

    // multiplier stage control
    typedef struct packed {
        logic load_rg;
        logic load_prod;
        logic backward;
    } mul_ctrl_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [WGT_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [WGT_W-1:0] r;
        if ((v[SAT_W-1:WGT_W-1] == '0) || (v[SAT_W-1:WGT_W-1] == '1))
            r = v[WGT_W-1:0];
        else if (v[SAT_W-1])
            r = {1'b1, {(WGT_W-1){1'b0}}};
        else
            r = {1'b0, {(WGT_W-1){1'b1}}};
        return r;
    endfunction

endpackage

[design/lsgd_if.sv]
// handshake channels of the sgd engine: feature items, results, configuration

interface lsgd_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     mode;
    logic signed [lsgd_pkg::FEAT_W-1:0]       feature;
    logic signed [lsgd_pkg::FEAT_W-1:0]       gradient;
    logic                                     last_in_row;

    modport source (output valid, mode, feature, gradient, last_in_row, input ready);
    modport sink   (input valid, mode, feature, gradient, last_in_row, output ready);
endinterface

interface lsgd_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [lsgd_pkg::WGT_W-1:0]        prediction;
    logic                                     is_update;
    logic                                     size_error;

    modport source (output valid, prediction, is_update, size_error, input ready);
    modport sink   (input valid, prediction, is_update, size_error, output ready);
endinterface

interface lsgd_cfg_if;
    logic                                     valid;
    logic                                     ready;
    logic [lsgd_pkg::CFG_IDX_W-1:0]           index;
    logic [lsgd_pkg::CFG_DATA_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/lsgd_wmem.sv]
// weight memory: single port, registered read, zeroing sweep after reset
module lsgd_wmem #(
    parameter int MAX_FEATURES = 64,
    parameter int ADDR_W       = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lsgd_pkg::wmem_ctrl_t                ctrl,
    input  logic [ADDR_W-1:0]                   addr,
    input  logic signed [lsgd_pkg::WGT_W-1:0]   wr_data,
    output logic signed [lsgd_pkg::WGT_W-1:0]   rd_data,
    output logic                                busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_FEATURES - 1);

    logic signed [lsgd_pkg::WGT_W-1:0] mem [MAX_FEATURES];
    logic signed [lsgd_pkg::WGT_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]                 clr_addr_reg;
    logic                              busy_reg;

    // clearing sweep, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
                busy_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // storage with registered read
    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (ctrl.wr_en)
            mem[addr] <= wr_data;
        if (ctrl.rd_en)
            rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

[design/lsgd_mul.sv]
// shared multiplier stage: rate times gradient, then weight or step product
module lsgd_mul (
    input  logic                                 clk,
    input  lsgd_pkg::mul_ctrl_t                  ctrl,
    input  logic [lsgd_pkg::RATE_W-1:0]          rate,
    input  logic signed [lsgd_pkg::FEAT_W-1:0]   grad,
    input  logic signed [lsgd_pkg::FEAT_W-1:0]   feat,
    input  logic signed [lsgd_pkg::WGT_W-1:0]    weight,
    output logic signed [lsgd_pkg::RG_W-1:0]     rg,
    output logic signed [lsgd_pkg::PROD_W-1:0]   prod
);

    logic signed [lsgd_pkg::RG_W-1:0]   rg_reg;
    logic signed [lsgd_pkg::RG_W-1:0]   rg_next;
    logic signed [lsgd_pkg::RG_W-1:0]   mul_a;
    logic signed [lsgd_pkg::PROD_W-1:0] prod_reg;
    logic signed [lsgd_pkg::PROD_W-1:0] prod_next;

    // rate is an unsigned fraction, widened by one zero bit
    assign rg_next = lsgd_pkg::RG_W'($signed({1'b0, rate})) * lsgd_pkg::RG_W'(grad);

    // forward: feature times weight; backward: feature times rate-gradient
    assign mul_a     = ctrl.backward ? rg_reg : lsgd_pkg::RG_W'(weight);
    assign prod_next = lsgd_pkg::PROD_W'(mul_a) * lsgd_pkg::PROD_W'(feat);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_rg)
            rg_reg <= rg_next;
        if (ctrl.load_prod)
            prod_reg <= prod_next;
    end

    assign rg   = rg_reg;
    assign prod = prod_reg;

endmodule

[design/linear_model_sgd_engine.sv]
// top level of the linear model sgd engine: sequencer, accumulator, bias, result register
//
//  channel   dir  handshake      payload
//  items     in   valid/ready    mode, feature, gradient, last_in_row
//  results   out  valid/ready    prediction, is_update, size_error
//  cfg       in   valid/ready    index, data (ready always high)
//
// an item passes through accept with weight read, multiply, then write-back or
// accumulate; the row's last item then passes a finish step that forms the result.
// the weight memory's single port and the shared multiplier keep items from overlapping.
// after reset the weight memory is zeroed with items held off.
// a waiting result does not block the next item; a new last item waits for the slot.

`include "linear_model_sgd_engine_defines.svh"

module linear_model_sgd_engine #(
    parameter int MAX_FEATURES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    lsgd_in_if.sink     items,
    lsgd_out_if.source  results,
    lsgd_cfg_if.sink    cfg
);

    localparam int CNT_W  = $clog2(MAX_FEATURES + 1);
    localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CMP_W  = (CNT_W > lsgd_pkg::FCNT_W) ? CNT_W : lsgd_pkg::FCNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_WB,
        S_FIN
    } state_t;

    state_t                              state_reg;
    logic [lsgd_pkg::RATE_W-1:0]         rate_reg;
    logic [lsgd_pkg::FCNT_W-1:0]         fcount_reg;
    logic [CNT_W-1:0]                    feature_index_reg;
    logic                                overflow_reg;
    logic signed [lsgd_pkg::ACC_W-1:0]   acc_reg;
    logic signed [lsgd_pkg::WGT_W-1:0]   bias_reg;
    logic                                mode_reg;
    logic signed [lsgd_pkg::FEAT_W-1:0]  feat_reg;
    logic                                last_reg;
    logic                                in_range_reg;
    logic                                out_valid_reg;
    logic signed [lsgd_pkg::WGT_W-1:0]   prediction_reg;
    logic                                is_update_reg;
    logic                                size_error_reg;

    logic                                in_accept;
    logic                                in_range_now;
    logic                                out_free;
    logic                                clr_busy;
    lsgd_pkg::wmem_ctrl_t                mem_ctrl;
    lsgd_pkg::mul_ctrl_t                 mul_ctrl;
    logic signed [lsgd_pkg::WGT_W-1:0]   rd_weight;
    logic signed [lsgd_pkg::WGT_W-1:0]   weight_next;
    logic signed [lsgd_pkg::RG_W-1:0]    rg;
    logic signed [lsgd_pkg::PROD_W-1:0]  prod;
    logic signed [lsgd_pkg::ACC_W-1:0]   acc_next;
    logic signed [lsgd_pkg::WGT_W-1:0]   bias_next;
    logic signed [lsgd_pkg::WGT_W-1:0]   prediction_next;

    // position check against min(feature_count, MAX_FEATURES)
    assign in_range_now = (CMP_W'(feature_index_reg) < CMP_W'(fcount_reg))
                       && (CMP_W'(feature_index_reg) < CMP_W'(MAX_FEATURES));

    // handshakes
    assign items.ready = (state_reg == S_IDLE) && !clr_busy;
    assign in_accept   = items.valid && items.ready;
    assign cfg.ready   = 1'b1;
    assign out_free    = !out_valid_reg || results.ready;

    // memory and multiplier control
    assign mem_ctrl.rd_en     = in_accept && in_range_now;
    assign mem_ctrl.wr_en     = (state_reg == S_WB) && in_range_reg && mode_reg;
    assign mul_ctrl.load_rg   = in_accept;
    assign mul_ctrl.load_prod = (state_reg == S_MUL);
    assign mul_ctrl.backward  = mode_reg;

    lsgd_wmem #(
        .MAX_FEATURES (MAX_FEATURES),
        .ADDR_W       (ADDR_W)
    ) u_wmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mem_ctrl),
        .addr    (feature_index_reg[ADDR_W-1:0]),
        .wr_data (weight_next),
        .rd_data (rd_weight),
        .busy    (clr_busy)
    );

    lsgd_mul u_mul (
        .clk    (clk),
        .ctrl   (mul_ctrl),
        .rate   (rate_reg),
        .grad   (items.gradient),
        .feat   (feat_reg),
        .weight (rd_weight),
        .rg     (rg),
        .prod   (prod)
    );

    // weight step, accumulation, bias step and prediction; shifted terms floor-truncated
    assign weight_next = lsgd_pkg::sat32(lsgd_pkg::SAT_W'(rd_weight)
                         - lsgd_pkg::SAT_W'(prod >>> lsgd_pkg::BWD_SHIFT));
    assign acc_next    = acc_reg + lsgd_pkg::ACC_W'(prod >>> lsgd_pkg::FWD_SHIFT);
    assign bias_next   = lsgd_pkg::sat32(lsgd_pkg::SAT_W'(bias_reg)
                         - lsgd_pkg::SAT_W'(rg >>> lsgd_pkg::BIAS_SHIFT));
    assign prediction_next = lsgd_pkg::sat32(lsgd_pkg::SAT_W'(acc_reg)
                             + lsgd_pkg::SAT_W'(bias_reg));

    // sequencer, row state, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            rate_reg          <= lsgd_pkg::RATE_RESET;
            fcount_reg        <= lsgd_pkg::FCNT_RESET;
            feature_index_reg <= '0;
            overflow_reg      <= 1'b0;
            acc_reg           <= '0;
            bias_reg          <= '0;
            mode_reg          <= 1'b0;
            feat_reg          <= '0;
            last_reg          <= 1'b0;
            in_range_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            prediction_reg    <= '0;
            is_update_reg     <= 1'b0;
            size_error_reg    <= 1'b0;
        end
        else
        begin
            // result valid: loaded at row finish, cleared once taken
            if ((state_reg == S_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (results.valid && results.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        mode_reg     <= items.mode;
                        feat_reg     <= items.feature;
                        last_reg     <= items.last_in_row;
                        in_range_reg <= in_range_now;
                        state_reg    <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (in_range_reg)
                    begin
                        if (!mode_reg)
                            acc_reg <= acc_next;
                        feature_index_reg <= feature_index_reg + CNT_W'(1);
                    end
                    else
                        overflow_reg <= 1'b1;
                    state_reg <= last_reg ? S_FIN : S_IDLE;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        prediction_reg    <= mode_reg ? '0 : prediction_next;
                        is_update_reg     <= mode_reg;
                        size_error_reg    <= overflow_reg;
                        if (mode_reg)
                            bias_reg <= bias_next;
                        acc_reg           <= '0;
                        feature_index_reg <= '0;
                        overflow_reg      <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // register writes; unknown indexes are dropped
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    lsgd_pkg::REG_LEARNING_RATE: rate_reg   <= cfg.data;
                    lsgd_pkg::REG_FEATURE_COUNT: fcount_reg <= cfg.data[lsgd_pkg::FCNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // result channel
    assign results.valid      = out_valid_reg;
    assign results.prediction = prediction_reg;
    assign results.is_update  = is_update_reg;
    assign results.size_error = size_error_reg;

    // checks
    `LSGD_ASSERT_NEXT(a_accept_starts_mul, clk, rst_n, in_accept, state_reg == S_MUL, "accepted transaction did not enter multiply")
    `LSGD_ASSERT_NOW(a_index_bounded, clk, rst_n, 1'b1, CMP_W'(feature_index_reg) <= CMP_W'(MAX_FEATURES), "feature index beyond memory depth")
    `LSGD_ASSERT_NOW(a_result_from_fin, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_FIN, "result raised outside row finish")
    `LSGD_ASSERT_NOW(a_no_write_while_clear, clk, rst_n, clr_busy, !mem_ctrl.rd_en && !mem_ctrl.wr_en && !in_accept, "memory access during clearing sweep")

endmodule
